// File: rtl/erm_pkg.sv
// Package with the types, constants and functions of the Euler rotation matrix block.
`default_nettype none
package erm_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int ENTRY_BITS = 16;
  localparam int STEPS = 30;
  localparam int VW = 33;
  localparam int ZW = 32;
  localparam int SHIFT_OUT = 32 - ENTRY_BITS;
  localparam logic signed [VW-1:0] GAIN = 33'sd652032874;

  typedef logic [$clog2(STEPS)-1:0] step_idx_t;

  // One input beat: three binary angles.
  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle_x;
    logic [ANGLE_BITS-1:0] angle_y;
    logic [ANGLE_BITS-1:0] angle_z;
  } in_t;

  // One result beat: the nine matrix entries, row by row.
  typedef struct packed {
    logic signed [ENTRY_BITS-1:0] r00;
    logic signed [ENTRY_BITS-1:0] r01;
    logic signed [ENTRY_BITS-1:0] r02;
    logic signed [ENTRY_BITS-1:0] r10;
    logic signed [ENTRY_BITS-1:0] r11;
    logic signed [ENTRY_BITS-1:0] r12;
    logic signed [ENTRY_BITS-1:0] r20;
    logic signed [ENTRY_BITS-1:0] r21;
    logic signed [ENTRY_BITS-1:0] r22;
  } out_t;

  // Rotation state of one angle inside the CORDIC chain.
  typedef struct packed {
    logic [1:0]           quad;
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  // Everything a chain cell hands to its neighbor.
  typedef struct packed {
    logic          valid;
    rot_t [2:0]    rot;
  } cell_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [ZW-1:0] atan_step(input step_idx_t i);
    logic signed [ZW-1:0] a;
    unique case (i)
      5'd0:  a = 32'sd536870912;
      5'd1:  a = 32'sd316933406;
      5'd2:  a = 32'sd167458907;
      5'd3:  a = 32'sd85004756;
      5'd4:  a = 32'sd42667331;
      5'd5:  a = 32'sd21354465;
      5'd6:  a = 32'sd10679838;
      5'd7:  a = 32'sd5340245;
      5'd8:  a = 32'sd2670163;
      5'd9:  a = 32'sd1335087;
      5'd10: a = 32'sd667544;
      5'd11: a = 32'sd333772;
      5'd12: a = 32'sd166886;
      5'd13: a = 32'sd83443;
      5'd14: a = 32'sd41722;
      5'd15: a = 32'sd20861;
      5'd16: a = 32'sd10430;
      5'd17: a = 32'sd5215;
      5'd18: a = 32'sd2608;
      5'd19: a = 32'sd1304;
      5'd20: a = 32'sd652;
      5'd21: a = 32'sd326;
      5'd22: a = 32'sd163;
      5'd23: a = 32'sd81;
      5'd24: a = 32'sd41;
      5'd25: a = 32'sd20;
      5'd26: a = 32'sd10;
      5'd27: a = 32'sd5;
      5'd28: a = 32'sd3;
      5'd29: a = 32'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Q2.30 product with rounding to nearest, ties upward.
  function automatic logic signed [VW-1:0] qmul(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [2*VW-1:0] p;
    p = a * b;
    p = p + (66'sd1 <<< 29);
    return p[VW+29:30];
  endfunction

  // Rounds a Q2.30 sum to the entry format and saturates.
  function automatic logic signed [ENTRY_BITS-1:0] to_entry(input logic signed [VW:0] v);
    logic signed [VW+1:0] t;
    logic signed [VW+1:0] r;
    logic signed [VW+1:0] hi;
    logic signed [VW+1:0] lo;
    hi = (VW+2)'((1 << (ENTRY_BITS - 1)) - 1);
    lo = -((VW+2)'(1) <<< (ENTRY_BITS - 1));
    t = {v[VW], v} + ((VW+2)'(1) <<< (SHIFT_OUT - 1));
    r = t >>> SHIFT_OUT;
    if (r > hi) begin
      return {1'b0, {(ENTRY_BITS-1){1'b1}}};
    end else if (r < lo) begin
      return {1'b1, {(ENTRY_BITS-1){1'b0}}};
    end
    return r[ENTRY_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/euler_rotation_matrix_top.sv
// Top level of the Euler angle to rotation matrix block.
//
// Usage: drive the three binary angles on angles and raise start for one cycle
// per beat. busy is always low, so a beat is taken at every clock edge with
// start high; one beat may follow another in every cycle.
// Each beat goes through a chain of 30 CORDIC cells (one micro-rotation per
// cell, all three angles side by side), then a quadrant stage, a stage of
// pairwise products, a stage of triple products and a rounding stage.
// Throughput is one beat per cycle, set by the one-cell-per-step chain.
// The result beat is on matrix for exactly one cycle with done high, and the
// receiver cannot stall it. Beats leave in the order they came in.
// Reset clears every valid flag in the chain, so no result appears until a
// new beat is accepted; data registers are not reset.
`default_nettype none
module euler_rotation_matrix_top (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  output logic             busy,
  input  erm_pkg::in_t     angles,
  output logic             done,
  output erm_pkg::out_t    matrix
);

  erm_pkg::cell_t chain [erm_pkg::STEPS+1];
  logic [erm_pkg::ANGLE_BITS-1:0] ang [3];

  assign busy = 1'b0;
  assign ang[0] = angles.angle_z;
  assign ang[1] = angles.angle_y;
  assign ang[2] = angles.angle_x;

  // Seed the chain: quadrant from the top bits, residue as starting angle.
  always_comb begin
    chain[0].valid = start;
    for (int k = 0; k < 3; k++) begin
      chain[0].rot[k].quad = ang[k][erm_pkg::ANGLE_BITS-1 -: 2];
      chain[0].rot[k].x    = erm_pkg::GAIN;
      chain[0].rot[k].y    = '0;
      chain[0].rot[k].z    = {2'b00, ang[k][erm_pkg::ANGLE_BITS-3:0],
                              {(32-erm_pkg::ANGLE_BITS){1'b0}}};
    end
  end

  for (genvar g = 0; g < erm_pkg::STEPS; g++) begin : g_cell
    erm_cordic_cell #(.STAGE(g)) u_cell (
      .clk (clk),
      .rst (rst),
      .d   (chain[g]),
      .q   (chain[g+1])
    );
  end

  erm_matrix u_matrix (
    .clk    (clk),
    .rst    (rst),
    .d      (chain[erm_pkg::STEPS]),
    .done   (done),
    .matrix (matrix)
  );

  // Every accepted beat yields a result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##34 done) else $error("result missing after accepted beat");

  // No result without an earlier accepted beat.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 34)) else $error("result without a beat");

  // A zero angle triple gives r00 and r02 of the identity matrix.
  a_identity: assert property (@(posedge clk) disable iff (rst)
    (start && angles.angle_x == '0 && angles.angle_y == '0 && angles.angle_z == '0)
    |-> ##34 (matrix.r00 == 16'sd16384 && matrix.r02 == 16'sd0))
    else $error("identity rotation wrong");

endmodule
`default_nettype wire

// File: rtl/erm_cordic_cell.sv
// One CORDIC micro-rotation cell, applied to all three angles at once.
`default_nettype none
module erm_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire                clk,
  input  wire                rst,
  input  erm_pkg::cell_t     d,
  output erm_pkg::cell_t     q
);

  localparam erm_pkg::step_idx_t IDX = erm_pkg::step_idx_t'(STAGE);
  localparam logic signed [erm_pkg::ZW-1:0] ATAN = erm_pkg::atan_step(IDX);

  erm_pkg::cell_t q_next;

  // Rotate toward zero residual angle, one step per lane.
  always_comb begin
    q_next.valid = d.valid;
    for (int k = 0; k < 3; k++) begin
      q_next.rot[k].quad = d.rot[k].quad;
      if (!d.rot[k].z[erm_pkg::ZW-1]) begin
        q_next.rot[k].x = d.rot[k].x - (d.rot[k].y >>> STAGE);
        q_next.rot[k].y = d.rot[k].y + (d.rot[k].x >>> STAGE);
        q_next.rot[k].z = d.rot[k].z - ATAN;
      end else begin
        q_next.rot[k].x = d.rot[k].x + (d.rot[k].y >>> STAGE);
        q_next.rot[k].y = d.rot[k].y - (d.rot[k].x >>> STAGE);
        q_next.rot[k].z = d.rot[k].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    q.rot <= q_next.rot;
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= q_next.valid;
    end
  end

endmodule
`default_nettype wire

// File: rtl/erm_matrix.sv
// Quadrant mapping, products and final rounding of the nine matrix entries.
`default_nettype none
module erm_matrix (
  input  wire                clk,
  input  wire                rst,
  input  erm_pkg::cell_t     d,
  output logic               done,
  output erm_pkg::out_t      matrix
);

  typedef logic signed [erm_pkg::VW-1:0] val_t;

  logic a_valid, b_valid, c_valid;
  val_t cx, sx, cy, sy, cz, sz;
  val_t c_arr [3];
  val_t s_arr [3];

  // Undo the quadrant split of each angle.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (d.rot[k].quad)
        2'd0: begin c_arr[k] = d.rot[k].x;  s_arr[k] = d.rot[k].y;  end
        2'd1: begin c_arr[k] = -d.rot[k].y; s_arr[k] = d.rot[k].x;  end
        2'd2: begin c_arr[k] = -d.rot[k].x; s_arr[k] = -d.rot[k].y; end
        default: begin c_arr[k] = d.rot[k].y; s_arr[k] = -d.rot[k].x; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cx <= c_arr[2]; sx <= s_arr[2];
    cy <= c_arr[1]; sy <= s_arr[1];
    cz <= c_arr[0]; sz <= s_arr[0];
  end

  // First products.
  val_t sxsy, cxsy, cycz, cysz, cxsz, cxcz, sxcy, sxsz, sxcz, cxcy, b_cz, b_sz, b_sy;
  always_ff @(posedge clk) begin
    sxsy <= erm_pkg::qmul(sx, sy);
    cxsy <= erm_pkg::qmul(cx, sy);
    cycz <= erm_pkg::qmul(cy, cz);
    cysz <= erm_pkg::qmul(cy, sz);
    cxsz <= erm_pkg::qmul(cx, sz);
    cxcz <= erm_pkg::qmul(cx, cz);
    sxcy <= erm_pkg::qmul(sx, cy);
    sxsz <= erm_pkg::qmul(sx, sz);
    sxcz <= erm_pkg::qmul(sx, cz);
    cxcy <= erm_pkg::qmul(cx, cy);
    b_cz <= cz;
    b_sz <= sz;
    b_sy <= sy;
  end

  // Triple products; the plain terms ride along.
  val_t t10, t11, t20, t21;
  val_t c_cycz, c_cysz, c_cxsz, c_cxcz, c_sxcy, c_sxsz, c_sxcz, c_cxcy, c_sy;
  always_ff @(posedge clk) begin
    t10 <= erm_pkg::qmul(sxsy, b_cz);
    t11 <= erm_pkg::qmul(sxsy, b_sz);
    t20 <= erm_pkg::qmul(cxsy, b_cz);
    t21 <= erm_pkg::qmul(cxsy, b_sz);
    c_cycz <= cycz; c_cysz <= cysz; c_cxsz <= cxsz; c_cxcz <= cxcz;
    c_sxcy <= sxcy; c_sxsz <= sxsz; c_sxcz <= sxcz; c_cxcy <= cxcy;
    c_sy <= b_sy;
  end

  // Sums, rounding and saturation into the result beat.
  always_ff @(posedge clk) begin
    matrix.r00 <= erm_pkg::to_entry({c_cycz[erm_pkg::VW-1], c_cycz});
    matrix.r01 <= erm_pkg::to_entry({c_cysz[erm_pkg::VW-1], c_cysz});
    matrix.r02 <= erm_pkg::to_entry(-{c_sy[erm_pkg::VW-1], c_sy});
    matrix.r10 <= erm_pkg::to_entry({t10[erm_pkg::VW-1], t10} - {c_cxsz[erm_pkg::VW-1], c_cxsz});
    matrix.r11 <= erm_pkg::to_entry({t11[erm_pkg::VW-1], t11} + {c_cxcz[erm_pkg::VW-1], c_cxcz});
    matrix.r12 <= erm_pkg::to_entry({c_sxcy[erm_pkg::VW-1], c_sxcy});
    matrix.r20 <= erm_pkg::to_entry({t20[erm_pkg::VW-1], t20} + {c_sxsz[erm_pkg::VW-1], c_sxsz});
    matrix.r21 <= erm_pkg::to_entry({t21[erm_pkg::VW-1], t21} - {c_sxcz[erm_pkg::VW-1], c_sxcz});
    matrix.r22 <= erm_pkg::to_entry({c_cxcy[erm_pkg::VW-1], c_cxcy});
  end

  // Valid flags follow the data through the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      a_valid <= d.valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      done    <= c_valid;
    end
  end

endmodule
`default_nettype wire
